FILE: hdl/prm_pkg.sv
// Shared constants, word types, state codes and the triangle base function.
package prm_pkg;

    localparam int MaxInd    = 256;
    localparam int IdxBits   = $clog2(MaxInd);
    localparam int CntBits   = IdxBits + 1;
    localparam int ValueBits = 32;
    localparam int TriSize   = MaxInd * (MaxInd + 1) / 2;
    localparam int AddrBits  = $clog2(TriSize);

    // Q2.(ValueBits-2) one
    localparam logic [ValueBits-1:0] OneFixed = {2'b01, {(ValueBits - 2){1'b0}}};

    localparam logic [1:0] OpAdd       = 2'd0;
    localparam logic [1:0] OpFounderWr = 2'd1;
    localparam logic [1:0] OpCommit    = 2'd2;
    localparam logic [1:0] OpRead      = 2'd3;

    localparam logic [1:0] StOk      = 2'd0;
    localparam logic [1:0] StFull    = 2'd1;
    localparam logic [1:0] StInvalid = 2'd2;

    typedef struct packed {
        logic [1:0]           operation;
        logic [CntBits-1:0]   sire;
        logic [CntBits-1:0]   dam;
        logic [IdxBits-1:0]   row_index;
        logic [IdxBits-1:0]   col_index;
        logic [ValueBits-1:0] coefficient;
    } prm_req_t;

    typedef struct packed {
        logic [ValueBits-1:0] coefficient_out;
        logic [IdxBits-1:0]   assigned_index;
        logic [1:0]           status;
    } prm_rsp_t;

    typedef struct packed {
        logic                 we;
        logic [AddrBits-1:0]  waddr;
        logic [ValueBits-1:0] wdata;
        logic [AddrBits-1:0]  raddr_a;
        logic [AddrBits-1:0]  raddr_b;
    } prm_mem_req_t;

    typedef struct packed {
        logic pass_pend;
        logic use_a;
        logic use_b;
        logic add_one;
    } prm_alu_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_BASE_S,
        ST_BASE_D,
        ST_ADD_COL,
        ST_ADD_DIAG,
        ST_COMMIT,
        ST_WAIT,
        ST_RD_ADDR,
        ST_RD_MEM,
        ST_RD_DATA,
        ST_FINISH
    } prm_state_t;

    // Start of row n in the packed lower triangle: n*(n+1)/2
    function automatic logic [AddrBits-1:0] tri_base(input logic [IdxBits-1:0] n);
        logic [2*CntBits-1:0] prod;
        prod = (2*CntBits)'(n) * ((2*CntBits)'(n) + 1'b1);
        return prod[AddrBits:1];
    endfunction

endpackage

FILE: hdl/pedigree_relationship_matrix.sv
// Top level: sequencer for the tabular build of the pedigree relationship matrix.
//
//  channel | direction | handshake             | word
//  --------+-----------+-----------------------+---------------------------------
//  req     | in        | req_valid / req_stall | prm_req_t (op, sire, dam, idx, coef)
//  rsp     | out       | rsp_valid / rsp_stall | prm_rsp_t (coef, index, status)
//
//  The add and commit sweeps write one store entry per cycle through the
//  single store write port. Reset clears the fill count but not the store:
//  rows become readable once fully written, so the store needs no clearing
//  pass. The pending founder flags clear at once. A finished word sits in
//  the output register; the next request is taken while it waits, and only
//  a second result stalls in FINISH behind it.
module pedigree_relationship_matrix (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  prm_pkg::prm_req_t req_word,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output prm_pkg::prm_rsp_t rsp_word
);

    prm_pkg::prm_state_t state_reg, state_next;

    prm_pkg::prm_req_t req_reg, req_next;
    prm_pkg::prm_rsp_t res_reg, res_next;
    prm_pkg::prm_rsp_t rsp_reg, rsp_next;
    logic              rsp_valid_reg, rsp_valid_next;

    // fill count and start of its row in the triangle
    logic [prm_pkg::CntBits-1:0]  next_reg, next_next;
    logic [prm_pkg::AddrBits-1:0] ibase_reg, ibase_next;

    // column sweep
    logic [prm_pkg::CntBits-1:0]  j_reg, j_next;
    logic [prm_pkg::AddrBits-1:0] colbase_reg, colbase_next;
    logic [prm_pkg::AddrBits-1:0] sbase_reg, sbase_next;
    logic [prm_pkg::AddrBits-1:0] dbase_reg, dbase_next;
    logic [prm_pkg::AddrBits-1:0] rd_addr_reg, rd_addr_next;

    // write-back stage: writes in the cycle after its reads
    logic                         wb_valid_reg, wb_valid_next;
    prm_pkg::prm_alu_ctl_t        wb_ctl_reg, wb_ctl_next;
    logic [prm_pkg::AddrBits-1:0] wb_addr_reg, wb_addr_next;

    prm_pkg::prm_mem_req_t          mem_req;
    logic [prm_pkg::ValueBits-1:0]  rdata_a;
    logic [prm_pkg::ValueBits-1:0]  rdata_b;
    logic [prm_pkg::ValueBits-1:0]  pend_rdata;
    logic [prm_pkg::ValueBits-1:0]  alu_out;
    logic                           pend_we;
    logic                           pend_clear;
    logic [prm_pkg::IdxBits-1:0]    pend_raddr;

    // shared row-base multiplier
    logic [prm_pkg::IdxBits-1:0]    mul_in;
    logic [prm_pkg::AddrBits-1:0]   mul_out;

    logic [prm_pkg::IdxBits-1:0]    sp;
    logic [prm_pkg::IdxBits-1:0]    dp;
    logic [prm_pkg::IdxBits-1:0]    j8;
    logic [prm_pkg::IdxBits-1:0]    rc_hi;
    logic [prm_pkg::IdxBits-1:0]    rc_lo;
    logic                           s_known;
    logic                           d_known;

    assign sp      = prm_pkg::IdxBits'(req_reg.sire - 1'b1);
    assign dp      = prm_pkg::IdxBits'(req_reg.dam - 1'b1);
    assign s_known = (req_reg.sire != '0);
    assign d_known = (req_reg.dam != '0);
    assign j8      = j_reg[prm_pkg::IdxBits-1:0];
    assign rc_hi   = (req_reg.row_index >= req_reg.col_index) ? req_reg.row_index
                                                             : req_reg.col_index;
    assign rc_lo   = (req_reg.row_index >= req_reg.col_index) ? req_reg.col_index
                                                             : req_reg.row_index;
    assign mul_out = prm_pkg::tri_base(mul_in);

    prm_store u_store (
        .clk     (clk),
        .req     (mem_req),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    prm_pend u_pend (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (pend_we),
        .waddr (req_reg.col_index),
        .wdata (req_reg.coefficient),
        .clear (pend_clear),
        .raddr (pend_raddr),
        .rdata (pend_rdata)
    );

    prm_alu u_alu (
        .ctl    (wb_ctl_reg),
        .a      (rdata_a),
        .b      (rdata_b),
        .pend   (pend_rdata),
        .result (alu_out)
    );

    assign req_stall = (state_reg != prm_pkg::ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        next_next      = next_reg;
        ibase_next     = ibase_reg;
        j_next         = j_reg;
        colbase_next   = colbase_reg;
        sbase_next     = sbase_reg;
        dbase_next     = dbase_reg;
        rd_addr_next   = rd_addr_reg;
        wb_valid_next  = 1'b0;
        wb_ctl_next    = wb_ctl_reg;
        wb_addr_next   = wb_addr_reg;
        pend_we        = 1'b0;
        pend_clear     = 1'b0;
        pend_raddr     = j8;
        mul_in         = '0;

        mem_req.we      = wb_valid_reg;
        mem_req.waddr   = wb_addr_reg;
        mem_req.wdata   = alu_out;
        mem_req.raddr_a = '0;
        mem_req.raddr_b = '0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            prm_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req_word;
                    state_next = prm_pkg::ST_DECODE;
                end
            end

            prm_pkg::ST_DECODE:
            begin
                res_next   = '{coefficient_out: '0, assigned_index: '0,
                               status: prm_pkg::StOk};
                state_next = prm_pkg::ST_FINISH;
                j_next       = '0;
                colbase_next = '0;
                if (req_reg.operation == prm_pkg::OpRead)
                begin
                    if ({1'b0, req_reg.row_index} >= next_reg ||
                        {1'b0, req_reg.col_index} >= next_reg)
                    begin
                        res_next.status = prm_pkg::StInvalid;
                    end
                    else
                    begin
                        res_next.assigned_index = req_reg.row_index;
                        state_next              = prm_pkg::ST_RD_ADDR;
                    end
                end
                else if (next_reg >= prm_pkg::CntBits'(prm_pkg::MaxInd))
                begin
                    res_next.status = prm_pkg::StFull;
                end
                else
                begin
                    unique case (req_reg.operation)
                        prm_pkg::OpFounderWr:
                        begin
                            if ({1'b0, req_reg.col_index} > next_reg)
                            begin
                                res_next.status = prm_pkg::StInvalid;
                            end
                            else
                            begin
                                pend_we                 = 1'b1;
                                res_next.assigned_index = next_reg[prm_pkg::IdxBits-1:0];
                            end
                        end
                        prm_pkg::OpCommit:
                        begin
                            res_next.assigned_index = next_reg[prm_pkg::IdxBits-1:0];
                            state_next              = prm_pkg::ST_COMMIT;
                        end
                        default:
                        begin
                            // add individual
                            if (req_reg.sire > next_reg || req_reg.dam > next_reg)
                            begin
                                res_next.status = prm_pkg::StInvalid;
                            end
                            else
                            begin
                                res_next.assigned_index = next_reg[prm_pkg::IdxBits-1:0];
                                state_next              = prm_pkg::ST_BASE_S;
                            end
                        end
                    endcase
                end
            end

            prm_pkg::ST_BASE_S:
            begin
                mul_in     = sp;
                sbase_next = mul_out;
                state_next = prm_pkg::ST_BASE_D;
            end

            prm_pkg::ST_BASE_D:
            begin
                mul_in     = dp;
                dbase_next = mul_out;
                state_next = prm_pkg::ST_ADD_COL;
            end

            prm_pkg::ST_ADD_COL:
            begin
                if (j_reg == next_reg)
                begin
                    state_next = prm_pkg::ST_ADD_DIAG;
                end
                else
                begin
                    // symmetric fetch of (sire, j) and (dam, j)
                    mem_req.raddr_a = (j8 <= sp) ? sbase_reg + prm_pkg::AddrBits'(j8)
                                                 : colbase_reg + prm_pkg::AddrBits'(sp);
                    mem_req.raddr_b = (j8 <= dp) ? dbase_reg + prm_pkg::AddrBits'(j8)
                                                 : colbase_reg + prm_pkg::AddrBits'(dp);
                    wb_valid_next = 1'b1;
                    wb_addr_next  = ibase_reg + prm_pkg::AddrBits'(j_reg);
                    wb_ctl_next   = '{pass_pend: 1'b0, use_a: s_known, use_b: d_known,
                                      add_one: 1'b0};
                    j_next        = j_reg + 1'b1;
                    colbase_next  = colbase_reg + prm_pkg::AddrBits'(j_reg) + 1'b1;
                end
            end

            prm_pkg::ST_ADD_DIAG:
            begin
                mem_req.raddr_a = (sp >= dp) ? sbase_reg + prm_pkg::AddrBits'(dp)
                                             : dbase_reg + prm_pkg::AddrBits'(sp);
                wb_valid_next = 1'b1;
                wb_addr_next  = ibase_reg + prm_pkg::AddrBits'(next_reg);
                wb_ctl_next   = '{pass_pend: 1'b0, use_a: s_known && d_known, use_b: 1'b0,
                                  add_one: 1'b1};
                state_next    = prm_pkg::ST_WAIT;
            end

            prm_pkg::ST_COMMIT:
            begin
                wb_valid_next = 1'b1;
                wb_addr_next  = ibase_reg + prm_pkg::AddrBits'(j_reg);
                wb_ctl_next   = '{pass_pend: 1'b1, use_a: 1'b0, use_b: 1'b0,
                                  add_one: 1'b0};
                if (j_reg == next_reg)
                begin
                    state_next = prm_pkg::ST_WAIT;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end

            prm_pkg::ST_WAIT:
            begin
                // diagonal is being written this cycle
                res_next.coefficient_out = alu_out;
                next_next  = next_reg + 1'b1;
                ibase_next = ibase_reg + prm_pkg::AddrBits'(next_reg) + 1'b1;
                pend_clear = (req_reg.operation == prm_pkg::OpCommit);
                state_next = prm_pkg::ST_FINISH;
            end

            prm_pkg::ST_RD_ADDR:
            begin
                mul_in       = rc_hi;
                rd_addr_next = mul_out + prm_pkg::AddrBits'(rc_lo);
                state_next   = prm_pkg::ST_RD_MEM;
            end

            prm_pkg::ST_RD_MEM:
            begin
                mem_req.raddr_a = rd_addr_reg;
                state_next      = prm_pkg::ST_RD_DATA;
            end

            prm_pkg::ST_RD_DATA:
            begin
                res_next.coefficient_out = rdata_a;
                state_next               = prm_pkg::ST_FINISH;
            end

            prm_pkg::ST_FINISH:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = prm_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = prm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= prm_pkg::ST_IDLE;
            rsp_valid_reg <= 1'b0;
            next_reg      <= '0;
            ibase_reg     <= '0;
            wb_valid_reg  <= 1'b0;
            j_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            next_reg      <= next_next;
            ibase_reg     <= ibase_next;
            wb_valid_reg  <= wb_valid_next;
            j_reg         <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        res_reg     <= res_next;
        rsp_reg     <= rsp_next;
        colbase_reg <= colbase_next;
        sbase_reg   <= sbase_next;
        dbase_reg   <= dbase_next;
        rd_addr_reg <= rd_addr_next;
        wb_ctl_reg  <= wb_ctl_next;
        wb_addr_reg <= wb_addr_next;
    end

`ifndef ASSERT_OFF
    // every store write lands in the row of the individual being built
    a_wb_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        wb_valid_reg |-> (wb_addr_reg >= ibase_reg &&
                          wb_addr_reg <= ibase_reg + prm_pkg::AddrBits'(next_reg)))
        else $error("store write outside current row");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        next_reg <= prm_pkg::CntBits'(prm_pkg::MaxInd))
        else $error("fill count beyond capacity");

    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (next_reg != $past(next_reg)) |-> (next_reg == $past(next_reg) + 1'b1))
        else $error("fill count moved by more than one");

    a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == prm_pkg::ST_FINISH && !(rsp_valid_reg && rsp_stall))
        |=> (rsp_valid_reg && state_reg == prm_pkg::ST_IDLE))
        else $error("finished word not handed to output register");
`endif

endmodule

FILE: hdl/prm_store.sv
// Packed lower-triangle coefficient memory: one write port, two registered read ports.
module prm_store (
    input  logic                          clk,
    input  prm_pkg::prm_mem_req_t         req,
    output logic [prm_pkg::ValueBits-1:0] rdata_a,
    output logic [prm_pkg::ValueBits-1:0] rdata_b
);

    logic [prm_pkg::ValueBits-1:0] mem [prm_pkg::TriSize];
    logic [prm_pkg::ValueBits-1:0] qa_reg;
    logic [prm_pkg::ValueBits-1:0] qb_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        qa_reg <= mem[req.raddr_a];
        qb_reg <= mem[req.raddr_b];
    end

    assign rdata_a = qa_reg;
    assign rdata_b = qb_reg;

endmodule

FILE: hdl/prm_pend.sv
// Pending founder row: data memory plus per-column written flags, cleared on commit.
module prm_pend (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          we,
    input  logic [prm_pkg::IdxBits-1:0]   waddr,
    input  logic [prm_pkg::ValueBits-1:0] wdata,
    input  logic                          clear,
    input  logic [prm_pkg::IdxBits-1:0]   raddr,
    output logic [prm_pkg::ValueBits-1:0] rdata
);

    logic [prm_pkg::ValueBits-1:0] mem [prm_pkg::MaxInd];
    logic [prm_pkg::ValueBits-1:0] q_reg;
    logic [prm_pkg::MaxInd-1:0]    valid_reg;
    logic [prm_pkg::MaxInd-1:0]    valid_next;
    logic                          hit_reg;
    logic                          hit_next;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        q_reg <= mem[raddr];
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (clear)
        begin
            valid_next = '0;
        end
        else if (we)
        begin
            valid_next[waddr] = 1'b1;
        end
        hit_next = valid_reg[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
        end
    end

    // unwritten column reads as zero
    assign rdata = hit_reg ? q_reg : '0;

endmodule

FILE: hdl/prm_alu.sv
// Shared halve-and-add unit, with a pass-through for committed founder values, for every value written to the store.
module prm_alu (
    input  prm_pkg::prm_alu_ctl_t         ctl,
    input  logic [prm_pkg::ValueBits-1:0] a,
    input  logic [prm_pkg::ValueBits-1:0] b,
    input  logic [prm_pkg::ValueBits-1:0] pend,
    output logic [prm_pkg::ValueBits-1:0] result
);

    logic [prm_pkg::ValueBits:0] term_a;
    logic [prm_pkg::ValueBits:0] term_b;
    logic [prm_pkg::ValueBits:0] term_c;
    logic [prm_pkg::ValueBits:0] sum;

    always_comb
    begin
        term_a = ctl.use_a   ? {2'b00, a[prm_pkg::ValueBits-1:1]} : '0;
        term_b = ctl.use_b   ? {2'b00, b[prm_pkg::ValueBits-1:1]} : '0;
        term_c = ctl.add_one ? {1'b0, prm_pkg::OneFixed} : '0;
        sum    = term_a + term_b + term_c;
        result = ctl.pass_pend ? pend : sum[prm_pkg::ValueBits-1:0];
    end

endmodule

FILE: bench/tb_pedigree_relationship_matrix.sv
// Testbench for pedigree_relationship_matrix: directed table, random words under idling and stalls, then a full store.
module tb_pedigree_relationship_matrix;
    timeunit 1ns;
    timeprecision 1ps;

    // Cap on the whole run, well above the longest legal run (adds being the
    // costliest words, plus receiver stalls).
    localparam int CycleLimit = 2_000_000;
    // Add at a full row plus drain margin; used for the quiet spell at the end.
    localparam int DrainCycles = 300;
    // Four idling phases share roughly 1170 random words.
    localparam int PhaseWords  = 293;
    localparam int NumDrill    = 25;
    localparam int ShownLimit  = 100;

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_stall;
    prm_pkg::prm_req_t req_word  = '0;
    logic              rsp_valid;
    logic              rsp_stall = 1'b0;
    prm_pkg::prm_rsp_t rsp_word;

    pedigree_relationship_matrix uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor state: packed lower triangle, the founder row being built,
    // and the number of individuals stored so far.
    // ------------------------------------------------------------------
    logic [prm_pkg::ValueBits-1:0] kin_store     [prm_pkg::TriSize];
    logic [prm_pkg::ValueBits-1:0] founder_draft [prm_pkg::MaxInd];
    int unsigned                   herd_size = 0;

    prm_pkg::prm_rsp_t answers_due [$];   // expected words, oldest first
    int unsigned       mismatches  = 0;
    int unsigned       words_sent  = 0;
    int unsigned       cycles      = 0;
    int unsigned       idle_pct    = 0;   // sender idle chance per cycle, percent
    int unsigned       stall_pct   = 0;   // receiver stall chance per cycle, percent

    // Slot of (a, b) in the packed lower triangle; order of a and b is free.
    function automatic int unsigned tri_slot(input int unsigned a, input int unsigned b);
        int unsigned hi;
        int unsigned lo;
        hi = (a >= b) ? a : b;
        lo = (a >= b) ? b : a;
        return hi * (hi + 1) / 2 + lo;
    endfunction

    // Applies one request word to the predictor state and returns the answer.
    function automatic prm_pkg::prm_rsp_t kinship_step(input prm_pkg::prm_req_t w);
        prm_pkg::prm_rsp_t           r;
        int unsigned                 s;
        int unsigned                 d;
        int unsigned                 n;
        int unsigned                 rw;
        int unsigned                 cl;
        logic [prm_pkg::ValueBits:0] acc;
        s  = w.sire;
        d  = w.dam;
        rw = w.row_index;
        cl = w.col_index;
        n  = herd_size;
        r  = '0;
        r.status = prm_pkg::StOk;
        if (w.operation == prm_pkg::OpRead)
        begin
            // reads are legal even with a full store
            if (rw >= n || cl >= n)
                r.status = prm_pkg::StInvalid;
            else
            begin
                r.coefficient_out = kin_store[tri_slot(rw, cl)];
                r.assigned_index  = w.row_index;
            end
        end
        else if (n >= prm_pkg::MaxInd)
            r.status = prm_pkg::StFull;
        else if (w.operation == prm_pkg::OpFounderWr)
        begin
            // column may reach the diagonal of the row in progress, not past it
            if (cl > n)
                r.status = prm_pkg::StInvalid;
            else
            begin
                founder_draft[cl] = w.coefficient;
                r.assigned_index  = prm_pkg::IdxBits'(n);
            end
        end
        else if (w.operation == prm_pkg::OpCommit)
        begin
            // unwritten columns land as zero; parents play no part
            for (int j = 0; j <= int'(n); j++)
                kin_store[tri_slot(n, j)] = founder_draft[j];
            for (int j = 0; j < prm_pkg::MaxInd; j++)
                founder_draft[j] = '0;
            herd_size         = n + 1;
            r.coefficient_out = kin_store[tri_slot(n, n)];
            r.assigned_index  = prm_pkg::IdxBits'(n);
        end
        else if (s > n || d > n)
            r.status = prm_pkg::StInvalid;
        else
        begin
            // new row: half of each known parent's row, halves truncated
            for (int j = 0; j < int'(n); j++)
            begin
                acc = '0;
                if (s > 0)
                    acc = acc + (kin_store[tri_slot(s - 1, j)] >> 1);
                if (d > 0)
                    acc = acc + (kin_store[tri_slot(d - 1, j)] >> 1);
                kin_store[tri_slot(n, j)] = acc[prm_pkg::ValueBits-1:0];
            end
            acc = {1'b0, prm_pkg::OneFixed};
            if (s > 0 && d > 0)
                acc = acc + (kin_store[tri_slot(s - 1, d - 1)] >> 1);
            kin_store[tri_slot(n, n)] = acc[prm_pkg::ValueBits-1:0];
            herd_size         = n + 1;
            r.coefficient_out = acc[prm_pkg::ValueBits-1:0];
            r.assigned_index  = prm_pkg::IdxBits'(n);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender. Valid is only ever lowered at the start of an idle spell and
    // raised once, so no step carries two assignments to it. The word is
    // predicted at the edge that accepts it; a typed answer, where given,
    // stands in for the prediction but the state still moves on.
    // ------------------------------------------------------------------
    task automatic send_word(input prm_pkg::prm_req_t w, input bit typed,
                             input prm_pkg::prm_rsp_t answer);
        prm_pkg::prm_rsp_t forecast;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        req_valid <= 1'b1;
        req_word  <= w;
        do @(posedge clk); while (req_stall);
        forecast = kinship_step(w);
        answers_due.push_back(typed ? answer : forecast);
        words_sent++;
    endtask

    // Known parent or unknown (zero), mostly known once there is a herd.
    function automatic logic [prm_pkg::CntBits-1:0] parent_pick();
        if (herd_size == 0 || $urandom_range(99) < 25)
            return '0;
        return prm_pkg::CntBits'($urandom_range(herd_size, 1));
    endfunction

    // Founder values: full-range noise plus values near one and its halves.
    function automatic logic [prm_pkg::ValueBits-1:0] founder_value();
        unique case ($urandom_range(3))
            0:       return prm_pkg::OneFixed;
            1:       return prm_pkg::OneFixed >> $urandom_range(6, 1);
            default: return prm_pkg::ValueBits'($urandom);
        endcase
    endfunction

    // One random choice: an add, a founder row (writes then commit), a read,
    // or a word with every field drawn at random.
    task automatic random_choice();
        prm_pkg::prm_req_t w;
        int unsigned       pick;
        int unsigned       top;
        pick = $urandom_range(99);
        top  = (herd_size < prm_pkg::MaxInd) ? herd_size : prm_pkg::MaxInd - 1;
        w    = '0;
        if (pick < 30)
        begin
            w.operation = prm_pkg::OpAdd;
            w.sire      = parent_pick();
            w.dam       = parent_pick();
            // a parent not yet born, now and then
            if (herd_size < prm_pkg::MaxInd && $urandom_range(99) < 8)
                w.dam = prm_pkg::CntBits'($urandom_range(prm_pkg::MaxInd, herd_size + 1));
            send_word(w, 1'b0, '0);
        end
        else if (pick < 42)
        begin
            repeat ($urandom_range(4))
            begin
                w             = '0;
                w.operation   = prm_pkg::OpFounderWr;
                w.col_index   = $urandom_range(1) ? prm_pkg::IdxBits'(top)
                                                  : prm_pkg::IdxBits'($urandom_range(top));
                w.coefficient = founder_value();
                send_word(w, 1'b0, '0);
            end
            w           = '0;
            w.operation = prm_pkg::OpCommit;
            w.sire      = prm_pkg::CntBits'($urandom_range(prm_pkg::MaxInd));
            w.dam       = prm_pkg::CntBits'($urandom_range(prm_pkg::MaxInd));
            send_word(w, 1'b0, '0);
        end
        else if (pick < 80)
        begin
            w.operation = prm_pkg::OpRead;
            if (herd_size == 0 || $urandom_range(99) < 10)
            begin
                w.row_index = prm_pkg::IdxBits'($urandom_range(prm_pkg::MaxInd - 1));
                w.col_index = prm_pkg::IdxBits'($urandom_range(prm_pkg::MaxInd - 1));
            end
            else
            begin
                w.row_index = prm_pkg::IdxBits'($urandom_range(herd_size - 1));
                w.col_index = prm_pkg::IdxBits'($urandom_range(herd_size - 1));
            end
            send_word(w, 1'b0, '0);
        end
        else
        begin
            w.operation   = 2'($urandom_range(3));
            w.sire        = prm_pkg::CntBits'($urandom_range(prm_pkg::MaxInd));
            w.dam         = prm_pkg::CntBits'($urandom_range(prm_pkg::MaxInd));
            w.row_index   = prm_pkg::IdxBits'($urandom_range(prm_pkg::MaxInd - 1));
            w.col_index   = prm_pkg::IdxBits'($urandom_range(prm_pkg::MaxInd - 1));
            w.coefficient = prm_pkg::ValueBits'($urandom);
            send_word(w, 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: checks each accepted word against the oldest expectation,
    // then draws the stall for the next cycle. Values read here are those
    // settled before the edge.
    // ------------------------------------------------------------------
    task automatic check_answer(input prm_pkg::prm_rsp_t got);
        prm_pkg::prm_rsp_t want;
        if (answers_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= ShownLimit)
                $display("%0t: unexpected word coef=%h idx=%0d status=%0d",
                         $time, got.coefficient_out, got.assigned_index, got.status);
            return;
        end
        want = answers_due.pop_front();
        if (got.coefficient_out !== want.coefficient_out ||
            got.assigned_index !== want.assigned_index || got.status !== want.status)
        begin
            mismatches++;
            if (mismatches <= ShownLimit)
                $display({"%0t: expected coef=%h idx=%0d status=%0d,",
                          " got coef=%h idx=%0d status=%0d"},
                         $time, want.coefficient_out, want.assigned_index, want.status,
                         got.coefficient_out, got.assigned_index, got.status);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
                check_answer(rsp_word);
            rsp_stall <= (stall_pct != 0 && $urandom_range(99) < stall_pct);
        end
    end

    // Run cap
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit)
        begin
            $display("pedigree_relationship_matrix verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Directed table, walked in order from an empty store. Answers are typed
    // in where they are plain (errors, empty store, founder extremes); the
    // rest fall to the predictor. Index in comments is the herd size before.
    // ------------------------------------------------------------------
    typedef struct packed {
        prm_pkg::prm_req_t word;
        logic              typed;
        prm_pkg::prm_rsp_t answer;
    } drill_row_t;

    localparam logic [prm_pkg::ValueBits-1:0] AllOnes = '1;
    localparam prm_pkg::prm_rsp_t Bad  = '{32'h0, 8'd0, prm_pkg::StInvalid};
    localparam prm_pkg::prm_rsp_t Any  = '0;
    localparam prm_pkg::prm_rsp_t Ok0  = '{32'h0, 8'd0, prm_pkg::StOk};
    localparam prm_pkg::prm_rsp_t Ok5  = '{32'h0, 8'd5, prm_pkg::StOk};

    localparam drill_row_t Drill [NumDrill] = '{
        // empty store: read, parents ahead, founder column ahead
        '{'{prm_pkg::OpRead,      9'd0,   9'd0,   8'd0,   8'd0, 32'h0}, 1'b1, Bad},
        '{'{prm_pkg::OpAdd,       9'd1,   9'd0,   8'd0,   8'd0, 32'h0}, 1'b1, Bad},
        '{'{prm_pkg::OpAdd,       9'd0,   9'd1,   8'd0,   8'd0, 32'h0}, 1'b1, Bad},
        '{'{prm_pkg::OpFounderWr, 9'd0,   9'd0,   8'd0,   8'd1, 32'h0}, 1'b1, Bad},
        // founder 0 with an all-ones diagonal, parents ignored on commit
        '{'{prm_pkg::OpFounderWr, 9'd0,   9'd0,   8'd0,   8'd0, AllOnes}, 1'b1, Ok0},
        '{'{prm_pkg::OpCommit,    9'd256, 9'd256, 8'd0,   8'd0, 32'h0}, 1'b1,
          '{AllOnes, 8'd0, prm_pkg::StOk}},
        // founder 1 never written: zero diagonal
        '{'{prm_pkg::OpCommit,    9'd0,   9'd0,   8'd0,   8'd0, 32'h0}, 1'b1,
          '{32'h0, 8'd1, prm_pkg::StOk}},
        // both parents unknown: diagonal one
        '{'{prm_pkg::OpAdd,       9'd0,   9'd0,   8'd0,   8'd0, 32'h0}, 1'b1,
          '{prm_pkg::OneFixed, 8'd2, prm_pkg::StOk}},
        '{'{prm_pkg::OpAdd,       9'd1,   9'd3,   8'd0,   8'd0, 32'h0}, 1'b0, Any},
        // selfing on the all-ones founder
        '{'{prm_pkg::OpAdd,       9'd1,   9'd1,   8'd0,   8'd0, 32'h0}, 1'b0, Any},
        // symmetric reads, then reads past the herd
        '{'{prm_pkg::OpRead,      9'd0,   9'd0,   8'd4,   8'd0, 32'h0}, 1'b0, Any},
        '{'{prm_pkg::OpRead,      9'd0,   9'd0,   8'd0,   8'd4, 32'h0}, 1'b0, Any},
        '{'{prm_pkg::OpRead,      9'd0,   9'd0,   8'd0,   8'd0, 32'h0}, 1'b1,
          '{AllOnes, 8'd0, prm_pkg::StOk}},
        '{'{prm_pkg::OpRead,      9'd0,   9'd0,   8'd255, 8'd0, 32'h0}, 1'b1, Bad},
        '{'{prm_pkg::OpRead,      9'd0,   9'd0,   8'd0,   8'd5, 32'h0}, 1'b1, Bad},
        // founder 5: diagonal and one column, two writes past the diagonal
        '{'{prm_pkg::OpFounderWr, 9'd0,   9'd0,   8'd0,   8'd5, prm_pkg::OneFixed},
          1'b1, Ok5},
        '{'{prm_pkg::OpFounderWr, 9'd0,   9'd0,   8'd0,   8'd0, 32'h12345678}, 1'b1, Ok5},
        '{'{prm_pkg::OpFounderWr, 9'd0,   9'd0,   8'd0,   8'd6, 32'h0}, 1'b1, Bad},
        '{'{prm_pkg::OpFounderWr, 9'd0,   9'd0,   8'd0,   8'd255, AllOnes}, 1'b1, Bad},
        '{'{prm_pkg::OpCommit,    9'd0,   9'd0,   8'd0,   8'd0, 32'h0}, 1'b0, Any},
        // parent numbers past the herd, then a valid add and reads of its row
        '{'{prm_pkg::OpAdd,       9'd256, 9'd0,   8'd0,   8'd0, 32'h0}, 1'b1, Bad},
        '{'{prm_pkg::OpAdd,       9'd6,   9'd256, 8'd0,   8'd0, 32'h0}, 1'b1, Bad},
        '{'{prm_pkg::OpAdd,       9'd6,   9'd4,   8'd0,   8'd0, 32'h0}, 1'b0, Any},
        '{'{prm_pkg::OpRead,      9'd0,   9'd0,   8'd6,   8'd5, 32'h0}, 1'b0, Any},
        '{'{prm_pkg::OpRead,      9'd0,   9'd0,   8'd6,   8'd0, 32'h0}, 1'b0, Any}
    };

    // ------------------------------------------------------------------
    // Main sequence. Reset once, the table, four idling phases of random
    // words, a top-up to a full store with the full-store answers, then drain.
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned       phase_start;
        prm_pkg::prm_req_t w;
        for (int j = 0; j < prm_pkg::TriSize; j++)
            kin_store[j] = '0;
        for (int j = 0; j < prm_pkg::MaxInd; j++)
            founder_draft[j] = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < NumDrill; k++)
            send_word(Drill[k].word, Drill[k].typed, Drill[k].answer);

        // random part: the store fills part way through, after which adds,
        // founder words and commits keep meeting the full store
        for (int phase = 0; phase < 4; phase++)
        begin
            unique case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 77; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 77; end
                default: begin idle_pct = 26; stall_pct = 26; end
            endcase
            phase_start = words_sent;
            while (words_sent - phase_start < PhaseWords)
                random_choice();
        end

        // make sure the full store has been met
        while (herd_size < prm_pkg::MaxInd)
        begin
            w           = '0;
            w.operation = prm_pkg::OpAdd;
            w.sire      = parent_pick();
            w.dam       = parent_pick();
            send_word(w, 1'b0, '0);
        end
        for (int op = 0; op < 3; op++)
        begin
            w           = '0;
            w.operation = 2'(op);
            send_word(w, 1'b1, '{32'h0, 8'd0, prm_pkg::StFull});
        end
        w           = '0;
        w.operation = prm_pkg::OpRead;
        w.row_index = 8'd255;
        w.col_index = 8'd255;
        send_word(w, 1'b0, '0);

        req_valid <= 1'b0;
        while (answers_due.size() != 0)
            @(posedge clk);
        // stray words after the last expected one still count
        repeat (DrainCycles) @(posedge clk);

        if (mismatches == 0 && answers_due.size() == 0)
            $display("pedigree_relationship_matrix verification clean");
        else
            $display("pedigree_relationship_matrix verification failed");
        $finish;
    end

endmodule

FILE: sim.f
hdl/prm_pkg.sv
hdl/prm_store.sv
hdl/prm_pend.sv
hdl/prm_alu.sv
hdl/pedigree_relationship_matrix.sv
bench/tb_pedigree_relationship_matrix.sv
